### design/stt_pkg.sv
// stt_pkg: shared types, character codes, token kinds and helper functions
// for the source text tokenizer. No dependencies.
package stt_pkg;

  // position and line counters
  localparam int OFFSET_BITS = 16;
  localparam logic [15:0] POS_LIM = (OFFSET_BITS >= 16) ? 16'hFFFF
                                    : 16'((32'd1 << OFFSET_BITS) - 32'd1);

  // result queue
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int MAX_PER_STEP = 3;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // pending operator codes
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_EQ    = 3'd1;
  localparam logic [2:0] OP_BANG  = 3'd2;
  localparam logic [2:0] OP_PLUS  = 3'd3;
  localparam logic [2:0] OP_MINUS = 3'd4;
  localparam logic [2:0] OP_SLASH = 3'd5;
  localparam logic [2:0] OP_STAR  = 3'd6;

  // token kinds
  localparam logic [4:0] KIND_ILLEGAL = 5'd0;
  localparam logic [4:0] KIND_END     = 5'd1;
  localparam logic [4:0] KIND_WORD    = 5'd2;
  localparam logic [4:0] KIND_INT     = 5'd3;
  localparam logic [4:0] KIND_FLOAT   = 5'd4;
  localparam logic [4:0] KIND_STRING  = 5'd5;
  localparam logic [4:0] KIND_ASSIGN  = 5'd6;
  localparam logic [4:0] KIND_EQEQ    = 5'd7;
  localparam logic [4:0] KIND_BANG    = 5'd8;
  localparam logic [4:0] KIND_NOTEQ   = 5'd9;
  localparam logic [4:0] KIND_PLUS    = 5'd10;
  localparam logic [4:0] KIND_MINUS   = 5'd11;
  localparam logic [4:0] KIND_PLUSEQ  = 5'd12;
  localparam logic [4:0] KIND_MINUSEQ = 5'd13;
  localparam logic [4:0] KIND_SLASH   = 5'd14;
  localparam logic [4:0] KIND_SLASHEQ = 5'd15;
  localparam logic [4:0] KIND_STAR    = 5'd16;
  localparam logic [4:0] KIND_STAREQ  = 5'd17;
  localparam logic [4:0] KIND_LT      = 5'd18;
  localparam logic [4:0] KIND_GT      = 5'd19;
  localparam logic [4:0] KIND_SEMI    = 5'd20;
  localparam logic [4:0] KIND_COLON   = 5'd21;
  localparam logic [4:0] KIND_COMMA   = 5'd22;
  localparam logic [4:0] KIND_LPAREN  = 5'd23;
  localparam logic [4:0] KIND_RPAREN  = 5'd24;
  localparam logic [4:0] KIND_LBRACE  = 5'd25;
  localparam logic [4:0] KIND_RBRACE  = 5'd26;
  localparam logic [4:0] KIND_LBRACK  = 5'd27;
  localparam logic [4:0] KIND_RBRACK  = 5'd28;

  // one result item
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic        eot;
  } token_t;

  // results of one scan step, packed from slot 0 up
  typedef struct packed {
    logic [1:0]       count;
    token_t [MAX_PER_STEP-1:0] slot;
  } step_wr_t;

  function automatic token_t mk_token(logic [4:0] kind, logic [15:0] start,
                                      logic [15:0] len, logic [15:0] line,
                                      logic eot);
    token_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.eot   = eot;
    return t;
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v >= POS_LIM) ? POS_LIM : v + 16'd1;
  endfunction

  function automatic logic [15:0] span(logic [15:0] e, logic [15:0] b);
    return (e > b) ? e - b : 16'd0;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER});
  endfunction

  function automatic logic is_numch(logic [7:0] b);
    return (b inside {[8'h30:8'h39], CH_DOT});
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF});
  endfunction

  function automatic logic [2:0] op_code(logic [7:0] b);
    case (b)
      CH_EQ:    return OP_EQ;
      CH_BANG:  return OP_BANG;
      CH_PLUS:  return OP_PLUS;
      CH_MINUS: return OP_MINUS;
      CH_SLASH: return OP_SLASH;
      CH_STAR:  return OP_STAR;
      default:  return OP_NONE;
    endcase
  endfunction

  function automatic logic [4:0] op_single_kind(logic [2:0] code);
    case (code)
      OP_EQ:    return KIND_ASSIGN;
      OP_BANG:  return KIND_BANG;
      OP_PLUS:  return KIND_PLUS;
      OP_MINUS: return KIND_MINUS;
      OP_SLASH: return KIND_SLASH;
      OP_STAR:  return KIND_STAR;
      default:  return KIND_ILLEGAL;
    endcase
  endfunction

  function automatic logic [4:0] op_double_kind(logic [2:0] code);
    case (code)
      OP_EQ:    return KIND_EQEQ;
      OP_BANG:  return KIND_NOTEQ;
      OP_PLUS:  return KIND_PLUSEQ;
      OP_MINUS: return KIND_MINUSEQ;
      OP_SLASH: return KIND_SLASHEQ;
      OP_STAR:  return KIND_STAREQ;
      default:  return KIND_ILLEGAL;
    endcase
  endfunction

  function automatic logic [4:0] punct_kind(logic [7:0] b);
    case (b)
      8'h3C:   return KIND_LT;
      8'h3E:   return KIND_GT;
      8'h3B:   return KIND_SEMI;
      8'h3A:   return KIND_COLON;
      8'h2C:   return KIND_COMMA;
      8'h28:   return KIND_LPAREN;
      8'h29:   return KIND_RPAREN;
      8'h7B:   return KIND_LBRACE;
      8'h7D:   return KIND_RBRACE;
      8'h5B:   return KIND_LBRACK;
      8'h5D:   return KIND_RBRACK;
      default: return KIND_ILLEGAL;
    endcase
  endfunction

endpackage

### design/stt_scan.sv
// stt_scan: input register and per-byte scanner state update; produces up
// to three result items per byte. Depends on stt_pkg.
module stt_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_final,
  input  logic              space_ok,
  output logic              wr_en,
  output stt_pkg::step_wr_t wr
);

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_OP    = 3'd1;
  localparam logic [2:0] M_WORD  = 3'd2;
  localparam logic [2:0] M_NUM   = 3'd3;
  localparam logic [2:0] M_STR   = 3'd4;
  localparam logic [2:0] M_CMT   = 3'd5;
  localparam logic [2:0] M_DRAIN = 3'd6;

  // input register
  logic       held;
  logic [7:0] b;
  logic       fin;
  logic       step_go;

  // scanner state
  logic [2:0]  mode, mode_next;
  logic [2:0]  pend_op, pend_op_next;
  logic        saw_dot, saw_dot_next;
  logic [15:0] tok_begin, tok_begin_next;
  logic [15:0] tok_line, tok_line_next;
  logic [15:0] offset, offset_next;
  logic [15:0] cur_line, cur_line_next;

  // step candidates: mode result, new-byte result, final flush, final end
  stt_pkg::token_t cand [4];
  logic [3:0]      cand_v;
  logic            used;
  logic            stop;
  logic            do_reset;

  assign step_go  = held && space_ok;
  assign in_ready = !held || step_go;
  assign wr_en    = step_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_ready && in_valid) begin
      b   <= in_byte;
      fin <= in_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      pend_op   <= stt_pkg::OP_NONE;
      saw_dot   <= 1'b0;
      tok_begin <= 16'd0;
      tok_line  <= 16'd1;
      offset    <= 16'd0;
      cur_line  <= 16'd1;
    end else if (step_go) begin
      mode      <= mode_next;
      pend_op   <= pend_op_next;
      saw_dot   <= saw_dot_next;
      tok_begin <= tok_begin_next;
      tok_line  <= tok_line_next;
      offset    <= offset_next;
      cur_line  <= cur_line_next;
    end
  end

  // one scan step
  always_comb begin
    mode_next      = mode;
    pend_op_next   = pend_op;
    saw_dot_next   = saw_dot;
    tok_begin_next = tok_begin;
    tok_line_next  = tok_line;
    offset_next    = offset;
    cur_line_next  = cur_line;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end
    cand_v   = '0;
    used     = 1'b0;
    stop     = 1'b0;
    do_reset = 1'b0;

    if (mode == M_DRAIN) begin
      // skip bytes after an end-of-text zero until the final one
      do_reset = fin;
    end else begin
      // continue or close the open token
      case (mode)
        M_OP: begin
          if (b == stt_pkg::CH_EQ) begin
            cand[0] = stt_pkg::mk_token(stt_pkg::op_double_kind(pend_op), tok_begin,
                                        16'd2, tok_line, 1'b0);
            cand_v[0] = 1'b1;
            mode_next = M_IDLE;
            used = 1'b1;
          end else if (pend_op == stt_pkg::OP_SLASH && b == stt_pkg::CH_SLASH) begin
            mode_next = M_CMT;
            used = 1'b1;
          end else begin
            cand[0] = stt_pkg::mk_token(stt_pkg::op_single_kind(pend_op), tok_begin,
                                        16'd1, tok_line, 1'b0);
            cand_v[0] = 1'b1;
            mode_next = M_IDLE;
          end
          pend_op_next = stt_pkg::OP_NONE;
        end
        M_WORD: begin
          if (stt_pkg::is_alpha(b) || stt_pkg::is_numch(b)) begin
            used = 1'b1;
          end else begin
            cand[0] = stt_pkg::mk_token(stt_pkg::KIND_WORD, tok_begin,
                                        stt_pkg::span(offset, tok_begin), tok_line, 1'b0);
            cand_v[0] = 1'b1;
            mode_next = M_IDLE;
          end
        end
        M_NUM: begin
          if (stt_pkg::is_numch(b)) begin
            if (b == stt_pkg::CH_DOT) begin
              saw_dot_next = 1'b1;
            end
            used = 1'b1;
          end else begin
            cand[0] = stt_pkg::mk_token(saw_dot ? stt_pkg::KIND_FLOAT : stt_pkg::KIND_INT,
                                        tok_begin, stt_pkg::span(offset, tok_begin),
                                        tok_line, 1'b0);
            cand_v[0] = 1'b1;
            saw_dot_next = 1'b0;
            mode_next = M_IDLE;
          end
        end
        M_STR: begin
          if (b == stt_pkg::CH_QUOTE) begin
            cand[0] = stt_pkg::mk_token(stt_pkg::KIND_STRING, tok_begin,
                                        stt_pkg::span(offset, tok_begin), tok_line, 1'b0);
            cand_v[0] = 1'b1;
            mode_next = M_IDLE;
          end
          used = 1'b1;
        end
        M_CMT: begin
          if (b == stt_pkg::CH_LF) begin
            mode_next = M_IDLE;
          end
          used = 1'b1;
        end
        default: begin
          mode_next = M_IDLE;
        end
      endcase

      // byte not taken by an open token starts something new
      if (!used) begin
        if (b == stt_pkg::CH_NUL) begin
          cand[1] = stt_pkg::mk_token(stt_pkg::KIND_END, offset, 16'd1, cur_line, 1'b1);
          cand_v[1] = 1'b1;
          stop = 1'b1;
          if (fin) begin
            do_reset = 1'b1;
          end else begin
            mode_next = M_DRAIN;
          end
        end else if (stt_pkg::is_space(b)) begin
          mode_next = mode_next;
        end else if (stt_pkg::op_code(b) != stt_pkg::OP_NONE) begin
          mode_next      = M_OP;
          pend_op_next   = stt_pkg::op_code(b);
          tok_begin_next = offset;
          tok_line_next  = cur_line;
        end else if (stt_pkg::is_alpha(b)) begin
          mode_next      = M_WORD;
          tok_begin_next = offset;
          tok_line_next  = cur_line;
        end else if (stt_pkg::is_numch(b)) begin
          mode_next      = M_NUM;
          saw_dot_next   = (b == stt_pkg::CH_DOT);
          tok_begin_next = offset;
          tok_line_next  = cur_line;
        end else if (b == stt_pkg::CH_QUOTE) begin
          mode_next      = M_STR;
          tok_begin_next = stt_pkg::sat_inc(offset);
          tok_line_next  = cur_line;
        end else begin
          cand[1] = stt_pkg::mk_token(stt_pkg::punct_kind(b), offset, 16'd1,
                                      cur_line, 1'b0);
          cand_v[1] = 1'b1;
        end
      end

      // counters, then flush at the final byte
      if (!stop) begin
        if (b == stt_pkg::CH_LF) begin
          cur_line_next = stt_pkg::sat_inc(cur_line);
        end
        offset_next = stt_pkg::sat_inc(offset);
        if (fin) begin
          case (mode_next)
            M_OP: begin
              cand[2] = stt_pkg::mk_token(stt_pkg::op_single_kind(pend_op_next),
                                          tok_begin_next, 16'd1, tok_line_next, 1'b0);
              cand_v[2] = 1'b1;
            end
            M_WORD: begin
              cand[2] = stt_pkg::mk_token(stt_pkg::KIND_WORD, tok_begin_next,
                                          stt_pkg::span(offset_next, tok_begin_next),
                                          tok_line_next, 1'b0);
              cand_v[2] = 1'b1;
            end
            M_NUM: begin
              cand[2] = stt_pkg::mk_token(saw_dot_next ? stt_pkg::KIND_FLOAT
                                                       : stt_pkg::KIND_INT,
                                          tok_begin_next,
                                          stt_pkg::span(offset_next, tok_begin_next),
                                          tok_line_next, 1'b0);
              cand_v[2] = 1'b1;
            end
            M_STR: begin
              cand[2] = stt_pkg::mk_token(stt_pkg::KIND_STRING, tok_begin_next,
                                          stt_pkg::span(offset_next, tok_begin_next),
                                          tok_line_next, 1'b0);
              cand_v[2] = 1'b1;
            end
            default: begin
              cand_v[2] = 1'b0;
            end
          endcase
          cand[3] = stt_pkg::mk_token(stt_pkg::KIND_END, offset_next, 16'd1,
                                      cur_line_next, 1'b1);
          cand_v[3] = 1'b1;
          do_reset = 1'b1;
        end
      end
    end

    // back to reset state at end of text
    if (do_reset) begin
      mode_next      = M_IDLE;
      pend_op_next   = stt_pkg::OP_NONE;
      saw_dot_next   = 1'b0;
      tok_begin_next = 16'd0;
      tok_line_next  = 16'd1;
      offset_next    = 16'd0;
      cur_line_next  = 16'd1;
    end
  end

  // pack valid candidates into consecutive slots
  always_comb begin
    logic [1:0] idx;
    idx = 2'd0;
    wr.slot = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && idx != 2'd3) begin
        wr.slot[idx] = cand[i];
        idx = idx + 2'd1;
      end
    end
    wr.count = idx;
  end

endmodule

### design/stt_queue.sv
// stt_queue: result queue taking up to three items per cycle and giving one
// per cycle to the output channel while it is ready. Depends on stt_pkg.
module stt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  stt_pkg::step_wr_t wr,
  output logic              space_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output stt_pkg::token_t   out_item
);

  stt_pkg::token_t              entries [stt_pkg::QDEPTH];
  logic [stt_pkg::QPTR_W-1:0]   wr_ptr;
  logic [stt_pkg::QPTR_W-1:0]   rd_ptr;
  logic [stt_pkg::QCNT_W-1:0]   count;
  logic [stt_pkg::QCNT_W-1:0]   count_next;
  logic [1:0]                   n_wr;
  logic                         rd_en;

  assign n_wr      = wr_en ? wr.count : 2'd0;
  assign out_valid = (count != '0);
  assign rd_en     = out_valid && out_ready;
  assign out_item  = entries[rd_ptr];
  assign space_ok  = (count <= stt_pkg::QCNT_W'(stt_pkg::QDEPTH - stt_pkg::MAX_PER_STEP));

  always_comb begin
    count_next = count + stt_pkg::QCNT_W'(n_wr) - stt_pkg::QCNT_W'(rd_en);
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + stt_pkg::QPTR_W'(n_wr);
      rd_ptr <= rd_ptr + stt_pkg::QPTR_W'(rd_en);
      count  <= count_next;
    end
  end

  // store the packed slots at consecutive entries
  always_ff @(posedge clk) begin
    for (int i = 0; i < stt_pkg::MAX_PER_STEP; i++) begin
      if (2'(i) < n_wr) begin
        entries[wr_ptr + stt_pkg::QPTR_W'(i)] <= wr.slot[i];
      end
    end
  end

endmodule

### design/source_text_tokenizer_unit.sv
// source_text_tokenizer_unit: top level of the source text tokenizer.
// Depends on stt_pkg, stt_scan and stt_queue.
//
// Source bytes enter on the s_ channel, one byte per item, s_tlast set on
// the final byte of a text. Tokens leave on the m_ channel, one per item,
// m_tlast set on the end token that closes each text.
// An accepted byte is held in the input register until the queue has room;
// the scan step then writes its results into an eight-entry queue, whose
// registered fill level raises m_tvalid for the first of those tokens.
// Throughput is one byte per cycle while the queue has room, with each
// scan step done in combinational logic. The output drains one token per
// cycle while m_tready is high, so up to three tokens of one byte queue up.
// s_tready stays high while the queue has room for three more tokens, so
// a stalled receiver is absorbed by the queue before input is held off.
// Synchronous reset empties the queue and input register and puts the
// scanner between tokens at offset zero, line one. At the final byte of
// each text the scanner returns to the same state for the next text.
module source_text_tokenizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // is_final
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] start_offset, [31:16] token_length,
                                 // [47:32] line_number
  output logic [4:0]  m_tuser,   // [4:0] token_kind
  output logic        m_tlast    // end_of_text
);

  logic              space_ok;
  logic              wr_en;
  stt_pkg::step_wr_t wr;
  stt_pkg::token_t   out_item;

  // byte scanner
  stt_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_final (s_tlast),
    .space_ok (space_ok),
    .wr_en    (wr_en),
    .wr       (wr)
  );

  // token queue
  stt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr        (wr),
    .space_ok  (space_ok),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  // output packing
  assign m_tdata = {out_item.line, out_item.len, out_item.start};
  assign m_tuser = out_item.kind;
  assign m_tlast = out_item.eot;

endmodule
